// ===== design/rmf_pkg.sv =====
// Shared types and constants for the rolling median filter.
package rmf_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_W    = 16;
    localparam int COUNT_W     = $clog2(WINDOW_MAX + 1);
    localparam int AGE_W       = $clog2(WINDOW_MAX);
    localparam int WLEN_W      = 7;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 7;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd5;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW_LENGTH = 4'd0,
        REG_PAD_OUTPUT    = 4'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PICK,
        ST_EMIT
    } state_t;

    // One window entry: value and number of samples that arrived after it
    typedef struct packed {
        sample_t            value;
        logic [AGE_W-1:0]   age;
    } cell_data_t;

    // Entry handed to the right neighbor when it is pushed out of place
    typedef struct packed {
        cell_data_t data;
        logic       push;
    } shift_t;

    // Broadcast to every cell for one update
    typedef struct packed {
        sample_t            sample;
        sample_t            old_value;
        logic               full;
        logic [COUNT_W-1:0] len_d;
    } bcast_t;

endpackage

// ===== design/rmf_in_if.sv =====
// Sample input channel.
interface rmf_in_if import rmf_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample;
    logic    start_req;

    modport source (output valid, sample, start_req, input ready);
    modport sink (input valid, sample, start_req, output ready);
endinterface

// ===== design/rmf_out_if.sv =====
// Median result channel.
interface rmf_out_if import rmf_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t median;
    logic    valid_res;

    modport source (output valid, median, valid_res, input ready);
    modport sink (input valid, median, valid_res, output ready);
endinterface

// ===== design/rmf_cfg_if.sv =====
// Configuration register write channel.
interface rmf_cfg_if import rmf_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/rmf_cell.sv =====
// One sorted-window cell: removes the oldest entry and inserts the new sample locally.
module rmf_cell import rmf_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic [AGE_W-1:0] idx,
    input  bcast_t           bc,
    input  cell_data_t       right_cur,
    input  shift_t           left_shift,
    output cell_data_t       cur,
    output shift_t           shift_out
);

    cell_data_t data_reg;
    cell_data_t data_next;
    cell_data_t del_data;
    logic       take_right;
    logic       del_valid;
    logic       del_gt;

    // Removal step: entries at or past the removed one move left by one
    always_comb
    begin
        take_right = bc.full && ($signed(data_reg.value) >= $signed(bc.old_value));
        del_data   = take_right ? right_cur : data_reg;
        del_valid  = {1'b0, idx} < bc.len_d;
        del_gt     = $signed(del_data.value) > $signed(bc.sample);
    end

    assign shift_out.data = del_data;
    assign shift_out.push = del_valid && del_gt;

    // Insertion step: larger entries move right, the sample lands after its equals
    always_comb
    begin
        if (left_shift.push)
        begin
            data_next.value = left_shift.data.value;
            data_next.age   = left_shift.data.age + AGE_W'(1);
        end
        else if (!del_valid || del_gt)
        begin
            data_next.value = bc.sample;
            data_next.age   = '0;
        end
        else
        begin
            data_next.value = del_data.value;
            data_next.age   = del_data.age + AGE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign cur = data_reg;

endmodule

// ===== design/rmf_chain.sv =====
// Row of sorted cells plus registered pick of the middle and oldest entries.
module rmf_chain import rmf_pkg::*; (
    input  logic               clk,
    input  logic               en,
    input  bcast_t             bc,
    input  logic               pick_en,
    input  logic [COUNT_W-1:0] n_eff,
    input  logic [COUNT_W-1:0] fill,
    output sample_t            lo_val,
    output sample_t            hi_val,
    output sample_t            oldest_val
);

    cell_data_t         cur      [WINDOW_MAX];
    cell_data_t         right_in [WINDOW_MAX];
    shift_t             shf      [WINDOW_MAX];
    shift_t             left_in  [WINDOW_MAX];
    logic [COUNT_W-1:0] half;
    logic [COUNT_W-1:0] nm1;
    logic [AGE_W-1:0]   hi_idx;
    logic [AGE_W-1:0]   lo_idx;
    sample_t            old_any;
    sample_t            lo_reg;
    sample_t            hi_reg;
    sample_t            oldest_reg;

    // Cell row, neighbors wired left and right
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        if (i == WINDOW_MAX - 1)
        begin : g_last
            assign right_in[i] = '0;
        end
        else
        begin : g_mid
            assign right_in[i] = cur[i+1];
        end

        if (i == 0)
        begin : g_first
            assign left_in[i] = '0;
        end
        else
        begin : g_rest
            assign left_in[i] = shf[i-1];
        end

        rmf_cell u_cell (
            .clk        (clk),
            .en         (en),
            .idx        (AGE_W'(i)),
            .bc         (bc),
            .right_cur  (right_in[i]),
            .left_shift (left_in[i]),
            .cur        (cur[i]),
            .shift_out  (shf[i])
        );
    end

    // Middle positions: same entry twice for odd lengths
    always_comb
    begin
        half   = n_eff >> 1;
        hi_idx = half[AGE_W-1:0];
        lo_idx = n_eff[0] ? hi_idx : hi_idx - AGE_W'(1);
        nm1    = n_eff - COUNT_W'(1);
    end

    // Oldest entry carries age n-1, unique within the filled part
    always_comb
    begin
        old_any = '0;
        for (int k = 0; k < WINDOW_MAX; k++)
        begin
            if (cur[k].age == nm1[AGE_W-1:0] && COUNT_W'(k) < fill)
            begin
                old_any = old_any | cur[k].value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pick_en)
        begin
            lo_reg     <= cur[lo_idx].value;
            hi_reg     <= cur[hi_idx].value;
            oldest_reg <= old_any;
        end
    end

    assign lo_val     = lo_reg;
    assign hi_val     = hi_reg;
    assign oldest_val = oldest_reg;

endmodule

// ===== design/rolling_median_filter.sv =====
// Rolling median filter top level: control, configuration registers, result register.
// A sample's result passes from the cell row through the pick registers into the output register.
// A new sample is taken only once the previous one has finished update, middle pick and
// result load, and the result load waits while the result register is stalled.
// With a window length of zero a sample is taken every cycle and yields nothing.
// Reset: window empty, window_length 5, pad_output 0; cell contents need no clearing.
module rolling_median_filter import rmf_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    rmf_in_if.sink      samples,
    rmf_out_if.source   results,
    rmf_cfg_if.sink     cfg
);

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] fill_reg, fill_next;
    logic [WLEN_W-1:0]  wl_reg, wl_next;
    logic               pad_reg, pad_next;
    logic               emit_reg, emit_next;
    logic               real_reg, real_next;
    logic               out_valid_reg, out_valid_next;
    sample_t            median_reg, median_next;
    logic               valid_res_reg, valid_res_next;

    logic [COUNT_W-1:0] n_eff;
    logic [COUNT_W-1:0] cnt0;
    logic [COUNT_W-1:0] cnt_inc;
    logic               accept;
    logic               full;
    logic               fills_now;
    logic               cell_en;
    logic               pick_en;
    logic               out_free;
    logic               out_load;
    logic               wl_write;
    bcast_t             bc;
    sample_t            lo_val;
    sample_t            hi_val;
    sample_t            oldest_val;
    logic [SAMPLE_W:0]  mid_sum;

    // Window state seen by the incoming sample
    always_comb
    begin
        if (32'(wl_reg) > WINDOW_MAX)
        begin
            n_eff = COUNT_W'(WINDOW_MAX);
        end
        else
        begin
            n_eff = COUNT_W'(wl_reg);
        end
        accept    = samples.valid && samples.ready;
        cnt0      = samples.start_req ? '0 : fill_reg;
        cnt_inc   = cnt0 + COUNT_W'(1);
        full      = (cnt0 == n_eff);
        fills_now = (cnt_inc == n_eff);
        cell_en   = accept && (n_eff != '0);
    end

    assign bc.sample    = samples.sample;
    assign bc.old_value = oldest_val;
    assign bc.full      = full;
    assign bc.len_d     = full ? cnt0 - COUNT_W'(1) : cnt0;

    rmf_chain u_chain (
        .clk        (clk),
        .en         (cell_en),
        .bc         (bc),
        .pick_en    (pick_en),
        .n_eff      (n_eff),
        .fill       (fill_reg),
        .lo_val     (lo_val),
        .hi_val     (hi_val),
        .oldest_val (oldest_val)
    );

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    always_comb
    begin
        wl_next  = wl_reg;
        pad_next = pad_reg;
        wl_write = 1'b0;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_WINDOW_LENGTH:
                begin
                    wl_next  = cfg.data[WLEN_W-1:0];
                    wl_write = 1'b1;
                end
                REG_PAD_OUTPUT:
                begin
                    pad_next = cfg.data[0];
                end
                default:
                begin
                    wl_next = wl_reg;
                end
            endcase
        end
    end

    // Fill count and result flags for the sample in flight
    always_comb
    begin
        fill_next = fill_reg;
        emit_next = emit_reg;
        real_next = real_reg;
        if (wl_write)
        begin
            fill_next = '0;
        end
        else if (accept)
        begin
            if (n_eff == '0)
            begin
                fill_next = cnt0;
            end
            else
            begin
                fill_next = full ? cnt0 : cnt_inc;
                emit_next = full || fills_now || pad_reg;
                real_next = full || fills_now;
            end
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cell_en)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!emit_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        samples.ready = 1'b0;
        pick_en       = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                samples.ready = 1'b1;
            end
            ST_PICK:
            begin
                pick_en = 1'b1;
            end
            ST_EMIT:
            begin
                out_load = emit_reg && out_free;
            end
            default:
            begin
                samples.ready = 1'b0;
            end
        endcase
    end

    // Result register: floor of the mean of the two middle entries, zero for padding results
    always_comb
    begin
        out_free       = !out_valid_reg || results.ready;
        mid_sum        = {lo_val[SAMPLE_W-1], lo_val} + {hi_val[SAMPLE_W-1], hi_val};
        median_next    = median_reg;
        valid_res_next = valid_res_reg;
        out_valid_next = out_valid_reg && !results.ready;
        if (out_load)
        begin
            median_next    = real_reg ? sample_t'(mid_sum[SAMPLE_W:1]) : '0;
            valid_res_next = real_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            wl_reg        <= WLEN_RESET;
            pad_reg       <= 1'b0;
            emit_reg      <= 1'b0;
            real_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            wl_reg        <= wl_next;
            pad_reg       <= pad_next;
            emit_reg      <= emit_next;
            real_reg      <= real_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg    <= median_next;
        valid_res_reg <= valid_res_next;
    end

    assign results.valid     = out_valid_reg;
    assign results.median    = median_reg;
    assign results.valid_res = valid_res_reg;

    // The window never holds more samples than its length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= n_eff)
        else $error("fill count above window length");

    // A sample into a nonzero window starts the pick step
    a_pick_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cell_en |=> state_reg == ST_PICK)
        else $error("pick step missing after update");

    // Padding results carry a zero median
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !valid_res_reg) |-> median_reg == '0)
        else $error("padding result with nonzero median");

    // Writing the window length empties the window
    a_len_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready && cfg.index == REG_WINDOW_LENGTH) |=> fill_reg == '0)
        else $error("window not emptied on length write");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !results.ready) |-> !out_load)
        else $error("result register overwritten");

endmodule
